// ===== hdl/rpd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rpd_pkg: shared types and constants for the permutation draw block
// Field widths, register indexes, status codes and controller/datapath links.
// ---------------------------------------------------------------------------
package rpd_pkg;

  localparam int CNT_W       = 11;   // n_size, draw_limit, position, value
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int EPOCH_W     = 8;    // restart tag stored with each entry
  localparam int MOD_BPC     = 4;    // remainder bits per cycle
  localparam int MOD_STEPS   = 32 / MOD_BPC;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam int XS_SH1  = 18;
  localparam int XS_SH2  = 27;
  localparam int ROT_LSB = 59;

  localparam logic [CNT_W-1:0] N_SIZE_RST     = 11'd1024;
  localparam logic [CNT_W-1:0] DRAW_LIMIT_RST = 11'd1024;
  localparam logic [63:0]      SEED_RST       = 64'd0;
  localparam logic [63:0]      INCR_RST       = 64'd1;

  localparam logic [CFG_IDX_W-1:0] REG_N_SIZE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_LIMIT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 8'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_LIMIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADLIM = 2'd2;

  typedef struct packed {
    logic acc_restart;  // item transfer with restart set
    logic clr_step;     // write one cleared tag entry
    logic tmod_start;   // start threshold remainder
    logic rmod_start;   // start index remainder
    logic mod_step;
    logic mul0;
    logic mul1;
    logic mul2;
    logic rng_upd;
    logic r_cap;
    logic rd_k;
    logic rd_p;
    logic wr_k;
    logic emit_err;
  } ctl_cmd_t;

  typedef struct packed {
    logic err;          // draw not allowed
    logic rej;          // raw output below threshold
    logic mod_last;
    logic clr_last;
    logic epoch_full;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/random_permutation_draw_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// random_permutation_draw_core: partial Fisher-Yates draw with PCG32
// Per draw: threshold remainder, generator step (partial products, state update,
//   output capture) and a test, repeated for each rejected generator output, then
//   index remainder and 3 table accesses on the single RAM port. Error results pass
//   through the check state and the output register. One draw at a time, next transfer on the cycle after the
//   strobe is set; out_strobe is high one cycle, the receiver cannot stall.
// Reset: a tag sweep over every table entry runs first (busy high); a restart every
//   255th time repeats it. Config writes are always taken.
// ---------------------------------------------------------------------------
module random_permutation_draw_core #(
  parameter int TABLE_DEPTH = rpd_pkg::TABLE_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire                           in_restart,
  output logic                          out_strobe,
  output logic [rpd_pkg::CNT_W-1:0]     out_value,
  output logic [rpd_pkg::STAT_W-1:0]    out_status,
  output logic                          out_last,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [rpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  rpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_restart (in_restart),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  rpd_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_value  (out_value),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

// ===== hdl/rpd_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rpd_ram: generic single-port RAM
// One write or read per cycle, registered read data (read before write).
// ---------------------------------------------------------------------------
module rpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hdl/rpd_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rpd_ctrl: draw sequencer
// Steps the datapath through clear, threshold, generator, rejection and swap.
// ---------------------------------------------------------------------------
module rpd_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                in_restart,
  input  rpd_pkg::dp_stat_t  stat,
  output rpd_pkg::ctl_cmd_t  cmd,
  output logic               busy
);
  import rpd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_TMOD  = 4'd3;
  localparam logic [3:0] S_MUL0  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_RCAP  = 4'd8;
  localparam logic [3:0] S_TEST  = 4'd9;
  localparam logic [3:0] S_RMOD  = 4'd10;
  localparam logic [3:0] S_RDK   = 4'd11;
  localparam logic [3:0] S_RDP   = 4'd12;
  localparam logic [3:0] S_WRK   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          pend_nxt = 1'b1;
          state_nxt = S_CHECK;
          if (in_restart) begin
            cmd.acc_restart = 1'b1;
            if (stat.epoch_full) state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = pend_r ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (stat.err) begin
          cmd.emit_err = 1'b1;
          pend_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          cmd.tmod_start = 1'b1;
          state_nxt = S_TMOD;
        end
      end
      S_TMOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0 = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.rng_upd = 1'b1;
        state_nxt = S_RCAP;
      end
      S_RCAP: begin
        cmd.r_cap = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (stat.rej) begin
          state_nxt = S_MUL0;
        end else begin
          cmd.rmod_start = 1'b1;
          state_nxt = S_RMOD;
        end
      end
      S_RMOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = S_RDK;
      end
      S_RDK: begin
        cmd.rd_k = 1'b1;
        state_nxt = S_RDP;
      end
      S_RDP: begin
        cmd.rd_p = 1'b1;
        state_nxt = S_WRK;
      end
      S_WRK: begin
        cmd.wr_k = 1'b1;
        pend_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;   // tag sweep after reset
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rpd_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rpd_dp: draw datapath
// Config registers, PCG32 generator, shared remainder unit and swap table.
// ---------------------------------------------------------------------------
module rpd_dp #(
  parameter int TABLE_DEPTH = rpd_pkg::TABLE_DEPTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire [rpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [rpd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rpd_pkg::ctl_cmd_t                 cmd,
  output rpd_pkg::dp_stat_t                 stat,
  output logic                              out_strobe,
  output logic [rpd_pkg::CNT_W-1:0]         out_value,
  output logic [rpd_pkg::STAT_W-1:0]        out_status,
  output logic                              out_last
);
  import rpd_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int WW = (IW > CNT_W) ? IW : CNT_W;
  localparam int DEPTH_CAP = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;
  localparam int RW = EPOCH_W + IW;

  function automatic logic [IW-1:0] to_idx(input logic [CNT_W-1:0] v);
    logic [WW-1:0] t;
    t = WW'(v);
    return t[IW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] to_cnt(input logic [IW-1:0] v);
    logic [WW-1:0] t;
    t = WW'(v);
    return t[CNT_W-1:0];
  endfunction

  // configuration
  logic [CNT_W-1:0] n_size_r, draw_limit_r;
  logic [63:0]      seed_r, incr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_size_r     <= N_SIZE_RST;
      draw_limit_r <= DRAW_LIMIT_RST;
      seed_r       <= SEED_RST;
      incr_r       <= INCR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_N_SIZE:     n_size_r     <= cfg_data[CNT_W-1:0];
        REG_DRAW_LIMIT: draw_limit_r <= cfg_data[CNT_W-1:0];
        REG_SEED:       seed_r       <= cfg_data;
        REG_INCREMENT:  incr_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // draw state
  logic [CNT_W-1:0]   pos_r;
  logic [63:0]        rng_r, acc_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [IW-1:0]      clr_cnt_r;
  logic [31:0]        r_r, thresh_r;

  logic [CNT_W-1:0] n_eff, bound, k;
  logic [IW-1:0]    k_idx, pos_idx;

  assign n_eff = (n_size_r > CNT_W'(DEPTH_CAP)) ? CNT_W'(DEPTH_CAP) : n_size_r;
  assign bound = n_eff - pos_r;

  // remainder unit, MOD_BPC quotient bits per cycle
  logic [31:0]          dvd_r;
  logic [CNT_W-1:0]     rem_r;
  logic [MOD_CNT_W-1:0] mcnt_r;
  logic [CNT_W-1:0]     rem_nxt;
  logic [CNT_W:0]       rt;

  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_BPC; i++) begin
      rt = {rem_nxt, dvd_r[31-i]};
      if (rt >= {1'b0, bound}) rt = rt - {1'b0, bound};
      rem_nxt = rt[CNT_W-1:0];
    end
  end

  assign k       = pos_r + rem_r;
  assign k_idx   = to_idx(k);
  assign pos_idx = to_idx(pos_r);

  // generator: low 64 bits of state * LCG_MUL from three 32x32 products
  logic [31:0] mul_a, mul_b, xs, rnd;
  logic [63:0] prod, rng_nxt;
  logic [4:0]  rot;
  logic [63:0] xs_w;

  assign mul_a   = cmd.mul1 ? rng_r[63:32] : rng_r[31:0];
  assign mul_b   = cmd.mul2 ? LCG_MUL[63:32] : LCG_MUL[31:0];
  assign prod    = mul_a * mul_b;
  assign rng_nxt = acc_r + {incr_r[63:1], 1'b1};
  assign xs_w    = ((rng_r >> XS_SH1) ^ rng_r) >> XS_SH2;
  assign xs      = xs_w[31:0];
  assign rot     = rng_r[63:ROT_LSB];
  assign rnd     = 32'({xs, xs} >> rot);

  // table: {tag, index}; tag equal to epoch means written since restart
  logic            ram_we;
  logic [IW-1:0]   ram_addr;
  logic [RW-1:0]   ram_wdata, ram_q;
  logic            q_valid;
  logic [IW-1:0]   q_val, picked_r;

  assign q_valid = (ram_q[RW-1:IW] == epoch_r);
  assign q_val   = q_valid ? ram_q[IW-1:0] : (cmd.wr_k ? pos_idx : k_idx);

  assign ram_we    = cmd.clr_step | cmd.wr_k;
  assign ram_addr  = cmd.clr_step ? clr_cnt_r : (cmd.rd_p ? pos_idx : k_idx);
  assign ram_wdata = cmd.clr_step ? '0 : {epoch_r, q_val};

  rpd_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  logic [STAT_W-1:0] err_code;
  always_comb begin
    if (draw_limit_r > n_eff)      err_code = ST_BADLIM;
    else if (pos_r >= draw_limit_r) err_code = ST_LIMIT;
    else                           err_code = ST_OK;
  end

  assign stat.err        = (err_code != ST_OK);
  assign stat.rej        = (r_r < thresh_r);
  assign stat.mod_last   = (mcnt_r == MOD_CNT_W'(MOD_STEPS - 1));
  assign stat.clr_last   = (clr_cnt_r == IW'(TABLE_DEPTH - 1));
  assign stat.epoch_full = (epoch_r == '1);

  logic out_strobe_r;
  logic [CNT_W-1:0]  out_value_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      rng_r        <= SEED_RST;
      epoch_r      <= '0;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_err | cmd.wr_k;
      if (cmd.acc_restart) begin
        pos_r <= '0;
        rng_r <= seed_r;
        if (!stat.epoch_full) epoch_r <= epoch_r + 1'b1;
      end
      if (cmd.clr_step) begin
        if (stat.clr_last) begin
          clr_cnt_r <= '0;
          epoch_r   <= EPOCH_W'(1);
        end else begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
      end
      if (cmd.rng_upd) rng_r <= rng_nxt;
      if (cmd.wr_k) pos_r <= pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tmod_start) begin
      dvd_r  <= 32'd0 - 32'(bound);
      rem_r  <= '0;
      mcnt_r <= '0;
    end else if (cmd.rmod_start) begin
      dvd_r  <= r_r;
      rem_r  <= '0;
      mcnt_r <= '0;
    end else if (cmd.mod_step) begin
      dvd_r  <= dvd_r << MOD_BPC;
      rem_r  <= rem_nxt;
      mcnt_r <= mcnt_r + 1'b1;
    end
    // remainder holds the threshold until the index remainder starts
    if (cmd.mul0) begin
      acc_r    <= prod;
      thresh_r <= 32'(rem_r);
    end else if (cmd.mul1 | cmd.mul2) begin
      acc_r <= acc_r + {prod[31:0], 32'd0};
    end
    if (cmd.r_cap) r_r <= rnd;
    if (cmd.rd_p) picked_r <= q_val;
    if (cmd.emit_err) begin
      out_value_r  <= '0;
      out_status_r <= err_code;
      out_last_r   <= 1'b0;
    end else if (cmd.wr_k) begin
      out_value_r  <= to_cnt(picked_r) + 1'b1;
      out_status_r <= ST_OK;
      out_last_r   <= (pos_r + 1'b1 == draw_limit_r);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire
